>>> src/tet_p2r_pkg.sv
// Shared widths and types for the tetrahedron point-to-reference-coordinate mapper.
// Depends on nothing; used by tet_point_to_reference_coords.
package tet_p2r_pkg;

    localparam int COORD_BITS       = 20;
    localparam int COORD_FRAC_BITS  = 12;
    localparam int RESULT_FRAC_BITS = 16;

    localparam int REG_W    = 60;
    localparam int NUM_REGS = 4;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = 2;
    localparam int PADDR_W  = IDX_W + 3;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int PROD_W  = DIFF_W + CROSS_W;
    localparam int DET_W   = PROD_W + 2;
    localparam int MAG_W   = DET_W;
    localparam int DEN_W   = MAG_W + 1;
    localparam int RES_W   = 32;
    localparam int QB      = RES_W + 1;
    localparam int REM_W   = DEN_W + QB;

    typedef logic [REG_W-1:0] vert_reg_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [DEN_W-1:0] den_t;
    typedef logic [QB-1:0] quo_t;

    // Sign-extended coordinate of a packed vertex; idx 0 is x
    function automatic diff_t vert_field(input vert_reg_t r, input int idx);
        logic [3*COORD_BITS+REG_W-1:0] padded;
        logic [COORD_BITS-1:0]         f;
        padded = {{(3*COORD_BITS){1'b0}}, r};
        f = padded[COORD_BITS*(2-idx) +: COORD_BITS];
        return diff_t'($signed(f));
    endfunction

endpackage

>>> src/tet_point_to_reference_coords.sv
// Top level of the tetrahedron point-to-reference-coordinate mapper.
// Uses tet_p2r_pkg for widths, types and vertex field extraction.
//
// Usage:
//   Write the four vertices over the APB port (64-bit data, register i at
//   byte address 8*i, each a 60-bit word of three Q8.12 fields, x highest)
//   while no point is in flight. Stream points on point_x/y/z with
//   in_valid; a word is taken when in_valid is high and in_stall low.
//   Each point yields one result word on ref_u/v/w (Q16.16), singular and
//   saturated, taken when out_valid is high and out_stall low.
//   Points pass through registered difference, cross product, product, sum,
//   magnitude, dividend and overflow stages, a restoring divider settling
//   one of 33 quotient bits per register, and the output register.
//   Throughput is one point per cycle unless stalled; every stage holds one word.
//   When the receiver stalls a full output, the whole pipeline holds and
//   in_stall rises; no word is lost or repeated.
//   Reset clears the vertices to zero and empties the pipeline.
module tet_point_to_reference_coords (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tet_p2r_pkg::PADDR_W-1:0]        paddr,
    input  logic [tet_p2r_pkg::DATA_W-1:0]         pwdata,
    output logic [tet_p2r_pkg::DATA_W-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [tet_p2r_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [tet_p2r_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [tet_p2r_pkg::COORD_BITS-1:0] point_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tet_p2r_pkg::RES_W-1:0]   ref_u,
    output logic signed [tet_p2r_pkg::RES_W-1:0]   ref_v,
    output logic signed [tet_p2r_pkg::RES_W-1:0]   ref_w,
    output logic                                   singular,
    output logic                                   saturated
);
    import tet_p2r_pkg::*;

    vert_reg_t vert_reg [NUM_REGS];
    logic [IDX_W-1:0] widx;
    logic adv;

    assign pready = 1'b1;
    assign widx   = paddr[PADDR_W-1:3];
    assign prdata = {{(DATA_W-REG_W){1'b0}}, vert_reg[widx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                vert_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            vert_reg[widx] <= pwdata[REG_W-1:0];
        end
    end

    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: edge vectors and right-hand side
    logic  vld1_reg;
    diff_t col_reg [3][3];
    diff_t rhs_reg [3];
    diff_t pt [3];
    assign pt[0] = diff_t'(point_x);
    assign pt[1] = diff_t'(point_y);
    assign pt[2] = diff_t'(point_z);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    col_reg[j][k] <= vert_field(vert_reg[j+1], k) - vert_field(vert_reg[0], k);
                end
                rhs_reg[k] <= pt[k] - vert_field(vert_reg[0], k);
            end
        end
    end

    // stage 2: cross products col1 x col2, col2 x col0, col0 x col1
    logic   vld2_reg;
    cross_t crs_reg [3][3];
    diff_t  rhs2_reg [3];
    diff_t  col0_2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    crs_reg[c][k] <=
                        cross_t'(col_reg[(c+1)%3][(k+1)%3]) * cross_t'(col_reg[(c+2)%3][(k+2)%3])
                      - cross_t'(col_reg[(c+1)%3][(k+2)%3]) * cross_t'(col_reg[(c+2)%3][(k+1)%3]);
                end
            end
            rhs2_reg   <= rhs_reg;
            col0_2_reg <= col_reg[0];
        end
    end

    // stage 3: dot-product terms; channel 3 is the matrix determinant
    logic  vld3_reg;
    prod_t prod_reg [4][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[c][k] <= prod_t'(rhs2_reg[k]) * prod_t'(crs_reg[c][k]);
                end
                prod_reg[3][k] <= prod_t'(col0_2_reg[k]) * prod_t'(crs_reg[0][k]);
            end
        end
    end

    // stage 4: determinants
    logic vld4_reg;
    det_t det_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                det_reg[c] <= det_t'(prod_reg[c][0]) + det_t'(prod_reg[c][1])
                            + det_t'(prod_reg[c][2]);
            end
        end
    end

    // stage 5: magnitudes and signs
    logic             vld5_reg;
    logic [MAG_W-1:0] mag_reg [4];
    logic             neg5_reg [3];
    logic             sing5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mag_reg[c] <= det_reg[c][DET_W-1] ? MAG_W'(-det_reg[c]) : MAG_W'(det_reg[c]);
            end
            for (int c = 0; c < 3; c++)
            begin
                neg5_reg[c] <= det_reg[c][DET_W-1] ^ det_reg[3][DET_W-1];
            end
            sing5_reg <= (det_reg[3] == '0);
        end
    end

    // stage 6: rounded dividend and doubled divisor
    logic vld6_reg;
    rem_t num6_reg [3];
    den_t den6_reg;
    logic neg6_reg [3];
    logic sing6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num6_reg[c] <= (REM_W'(mag_reg[c]) << (RESULT_FRAC_BITS + 1))
                             + REM_W'(mag_reg[3]);
            end
            den6_reg  <= {mag_reg[3], 1'b0};
            neg6_reg  <= neg5_reg;
            sing6_reg <= sing5_reg;
        end
    end

    // stage 7: quotient overflow check, then the divider pipeline
    logic dv_vld_reg  [QB+1];
    rem_t dv_rem_reg  [QB+1][3];
    quo_t dv_quo_reg  [QB+1][3];
    den_t dv_den_reg  [QB+1];
    logic dv_neg_reg  [QB+1][3];
    logic dv_ovf_reg  [QB+1][3];
    logic dv_sing_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= num6_reg[c];
                dv_quo_reg[0][c] <= '0;
                dv_ovf_reg[0][c] <= num6_reg[c] >= (REM_W'(den6_reg) << QB);
            end
            dv_den_reg[0]  <= den6_reg;
            dv_neg_reg[0]  <= neg6_reg;
            dv_sing_reg[0] <= sing6_reg;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_div
        localparam int BIT = QB - 1 - s;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (dv_rem_reg[s][c] >= (REM_W'(dv_den_reg[s]) << BIT))
                    begin
                        dv_rem_reg[s+1][c] <= dv_rem_reg[s][c] - (REM_W'(dv_den_reg[s]) << BIT);
                        dv_quo_reg[s+1][c] <= dv_quo_reg[s][c] | (QB'(1) << BIT);
                    end
                    else
                    begin
                        dv_rem_reg[s+1][c] <= dv_rem_reg[s][c];
                        dv_quo_reg[s+1][c] <= dv_quo_reg[s][c];
                    end
                end
                dv_den_reg[s+1]  <= dv_den_reg[s];
                dv_neg_reg[s+1]  <= dv_neg_reg[s];
                dv_ovf_reg[s+1]  <= dv_ovf_reg[s];
                dv_sing_reg[s+1] <= dv_sing_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[s+1] <= dv_vld_reg[s];
            end
        end
    end

    // output stage: clip, apply sign, force zero when singular
    logic [RES_W-1:0] res_next [3];
    logic             sat_next [3];
    quo_t             lim;
    quo_t             mval;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lim  = dv_neg_reg[QB][c] ? (QB'(1) << (RES_W - 1)) : ((QB'(1) << (RES_W - 1)) - QB'(1));
            sat_next[c] = dv_ovf_reg[QB][c] || (dv_quo_reg[QB][c] > lim);
            mval = sat_next[c] ? lim : dv_quo_reg[QB][c];
            res_next[c] = dv_neg_reg[QB][c] ? -mval[RES_W-1:0] : mval[RES_W-1:0];
            if (dv_sing_reg[QB])
            begin
                res_next[c] = '0;
                sat_next[c] = 1'b0;
            end
        end
    end

    logic signed [RES_W-1:0] ref_u_reg, ref_v_reg, ref_w_reg;
    logic                    singular_reg, saturated_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ref_u_reg     <= res_next[0];
            ref_v_reg     <= res_next[1];
            ref_w_reg     <= res_next[2];
            singular_reg  <= dv_sing_reg[QB];
            saturated_reg <= sat_next[0] || sat_next[1] || sat_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            vld4_reg      <= 1'b0;
            vld5_reg      <= 1'b0;
            vld6_reg      <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg      <= in_valid;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            vld4_reg      <= vld3_reg;
            vld5_reg      <= vld4_reg;
            vld6_reg      <= vld5_reg;
            dv_vld_reg[0] <= vld6_reg;
            out_valid_reg <= dv_vld_reg[QB];
        end
    end

    assign out_valid = out_valid_reg;
    assign ref_u     = ref_u_reg;
    assign ref_v     = ref_v_reg;
    assign ref_w     = ref_w_reg;
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> ref_u == '0 && ref_v == '0 && ref_w == '0 && !saturated)
        else $error("singular result with nonzero coordinates");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            ref_u == 32'sh7FFFFFFF || ref_u == 32'sh80000000 ||
            ref_v == 32'sh7FFFFFFF || ref_v == 32'sh80000000 ||
            ref_w == 32'sh7FFFFFFF || ref_w == 32'sh80000000)
        else $error("saturated flag without a clipped coordinate");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dv_vld_reg[QB]) && $stable(vld1_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
